FILE: rtl/core/plif_pkg.sv
// ----------------------------------------------------------------------------
// plif_pkg
// Shared widths, codes, bundles and saturation helper of the leaky-integral
// PID controller with feedforward.
// ----------------------------------------------------------------------------
package plif_pkg;

	localparam int PLIF_FRAC_BITS = 16;

	localparam int DATA_W   = 32;
	localparam int DT_W     = 24;
	localparam int DECAY_W  = 16;
	localparam int ACC_W    = 48;
	localparam int OPND_W   = 33;
	localparam int PROD_W   = 2 * OPND_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int DIV_N_W  = 64;
	localparam int DIV_Q_W  = 32;
	localparam int DIV_D_W  = 24;
	localparam int NUM_REGS = 7;
	localparam int ADDR_W   = 5;
	localparam int APB_W    = 32;

	localparam logic [DECAY_W:0] DECAY_ONE = (DECAY_W + 1)'(1) << DECAY_W;

	// Multiplier operand selection.
	typedef logic [2:0] plif_msel_t;
	localparam plif_msel_t MS_NONE   = 3'd0;
	localparam plif_msel_t MS_ACC_HI = 3'd1;
	localparam plif_msel_t MS_ACC_LO = 3'd2;
	localparam plif_msel_t MS_ERR_DT = 3'd3;
	localparam plif_msel_t MS_KI     = 3'd4;
	localparam plif_msel_t MS_KD     = 3'd5;
	localparam plif_msel_t MS_KP     = 3'd6;
	localparam plif_msel_t MS_FF     = 3'd7;

	// Use of the registered product.
	typedef logic [2:0] plif_op_t;
	localparam plif_op_t OP_NONE       = 3'd0;
	localparam plif_op_t OP_SUM_LOAD   = 3'd1;
	localparam plif_op_t OP_SUM_ADD_LO = 3'd2;
	localparam plif_op_t OP_ACC        = 3'd3;
	localparam plif_op_t OP_BR_INIT    = 3'd4;
	localparam plif_op_t OP_BRACKET    = 3'd5;
	localparam plif_op_t OP_DRV_INIT   = 3'd6;
	localparam plif_op_t OP_DRIVE      = 3'd7;

	localparam logic DS_DERIV = 1'b0;
	localparam logic DS_INTEG = 1'b1;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic       div_sel;
		plif_msel_t mul_sel;
		plif_op_t   op;
	} plif_cmd_t;

	typedef struct packed {
		logic zero_step;
		logic div_busy;
		logic div_done;
		logic out_free;
	} plif_stat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kd;
		logic signed [DATA_W-1:0] kff;
		logic [DECAY_W-1:0]       decay;
		logic                     ff_en;
		logic                     ctl_en;
	} plif_cfg_t;

	typedef struct packed {
		logic                    flag;
		logic signed [SUM_W-1:0] val;
	} plif_sat_t;

	// Clamp a wide signed value to a w-bit signed range and report the clip.
	function automatic plif_sat_t sat_to(input logic signed [SUM_W-1:0] x, input int w);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		plif_sat_t r;
		hi = $signed((SUM_W'(1) << (w - 1)) - SUM_W'(1));
		lo = ~hi;
		if (x > hi) begin
			r.flag = 1'b1;
			r.val  = hi;
		end else if (x < lo) begin
			r.flag = 1'b1;
			r.val  = lo;
		end else begin
			r.flag = 1'b0;
			r.val  = x;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/plif_ifs.sv
// ----------------------------------------------------------------------------
// plif_ifs
// Valid/ready channels for the samples in and the controller results out.
// ----------------------------------------------------------------------------
interface plif_sample_if;
	import plif_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] target;
	logic signed [DATA_W-1:0] measured;
	logic [DT_W-1:0]          time_step;

	modport source(output valid, target, measured, time_step, input ready);
	modport sink(input valid, target, measured, time_step, output ready);
endinterface

interface plif_result_if;
	import plif_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic                     saturated;
	logic                     zero_step;

	modport source(output valid, drive, saturated, zero_step, input ready);
	modport sink(input valid, drive, saturated, zero_step, output ready);
endinterface

FILE: rtl/core/plif_cfg.sv
// ----------------------------------------------------------------------------
// plif_cfg
// APB register file holding gains, decay and enables; any write in the map
// requests a clear of the loop state.
// ----------------------------------------------------------------------------
module plif_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [plif_pkg::ADDR_W-1:0]  paddr,
	input  logic [plif_pkg::APB_W-1:0]   pwdata,
	output logic [plif_pkg::APB_W-1:0]   prdata,
	output logic                         pready,
	output plif_pkg::plif_cfg_t          cfg,
	output logic                         clr
);
	import plif_pkg::*;

	localparam int IDX_W = ADDR_W - 2;
	localparam logic [IDX_W-1:0] REG_KP     = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_KI     = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_KD     = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_KFF    = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_DECAY  = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_FF_EN  = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_CTL_EN = IDX_W'(6);

	plif_cfg_t        cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign clr    = wr && (idx < IDX_W'(NUM_REGS));
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp     <= '0;
			cfg_q.ki     <= '0;
			cfg_q.kd     <= '0;
			cfg_q.kff    <= '0;
			cfg_q.decay  <= '0;
			cfg_q.ff_en  <= 1'b0;
			cfg_q.ctl_en <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_KP:     cfg_q.kp     <= $signed(pwdata[DATA_W-1:0]);
				REG_KI:     cfg_q.ki     <= $signed(pwdata[DATA_W-1:0]);
				REG_KD:     cfg_q.kd     <= $signed(pwdata[DATA_W-1:0]);
				REG_KFF:    cfg_q.kff    <= $signed(pwdata[DATA_W-1:0]);
				REG_DECAY:  cfg_q.decay  <= pwdata[DECAY_W-1:0];
				REG_FF_EN:  cfg_q.ff_en  <= pwdata[0];
				REG_CTL_EN: cfg_q.ctl_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KP:     prdata = APB_W'(cfg_q.kp);
			REG_KI:     prdata = APB_W'(cfg_q.ki);
			REG_KD:     prdata = APB_W'(cfg_q.kd);
			REG_KFF:    prdata = APB_W'(cfg_q.kff);
			REG_DECAY:  prdata = APB_W'(cfg_q.decay);
			REG_FF_EN:  prdata = APB_W'(cfg_q.ff_en);
			REG_CTL_EN: prdata = APB_W'(cfg_q.ctl_en);
			default:    prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/plif_div.sv
// ----------------------------------------------------------------------------
// plif_div
// Radix-4 restoring divider for unsigned magnitudes with a 32-bit quotient
// and an overflow flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module plif_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [plif_pkg::DIV_N_W-1:0]  numer,
	input  logic [plif_pkg::DIV_D_W-1:0]  denom,
	output logic                          busy,
	output logic                          done,
	output logic                          ovf,
	output logic [plif_pkg::DIV_Q_W-1:0]  quot
);
	import plif_pkg::*;

	localparam int STEPS = DIV_Q_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_Q_W-1:0] low_q;
	logic [DIV_Q_W-1:0] quot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic               ovf_q;

	logic [DIV_D_W:0]   t1;
	logic [DIV_D_W:0]   t2;
	logic [DIV_D_W-1:0] r1;
	logic [DIV_D_W-1:0] r2;
	logic               b1;
	logic               b2;

	// Two quotient bits per cycle; the partial remainder stays below the divisor
	// whenever the quotient does not overflow, so it fits the divisor width.
	always_comb begin
		t1 = {rem_q, low_q[DIV_Q_W-1]};
		b1 = t1 >= {1'b0, den_q};
		r1 = b1 ? DIV_D_W'(t1 - {1'b0, den_q}) : t1[DIV_D_W-1:0];
		t2 = {r1, low_q[DIV_Q_W-2]};
		b2 = t2 >= {1'b0, den_q};
		r2 = b2 ? DIV_D_W'(t2 - {1'b0, den_q}) : t2[DIV_D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// A high half at or above the divisor means the quotient needs more
			// than 32 bits.
			rem_q  <= numer[DIV_Q_W +: DIV_D_W];
			low_q  <= numer[DIV_Q_W-1:0];
			den_q  <= denom;
			ovf_q  <= numer[DIV_N_W-1:DIV_Q_W] >= (DIV_N_W - DIV_Q_W)'(denom);
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= r2;
			low_q  <= low_q << 2;
			quot_q <= {quot_q[DIV_Q_W-3:0], b1, b2};
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = quot_q;

endmodule

FILE: rtl/core/plif_dp.sv
// ----------------------------------------------------------------------------
// plif_dp
// Datapath: error and state registers, one shared 33x33 multiplier, the
// divider, the running sum with clamps and the result register.
// ----------------------------------------------------------------------------
module plif_dp #(
	parameter int FRAC_BITS = plif_pkg::PLIF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  plif_pkg::plif_cmd_t                 cmd,
	output plif_pkg::plif_stat_t                stat,
	input  plif_pkg::plif_cfg_t                 cfg,
	input  logic                                clr,
	input  logic signed [plif_pkg::DATA_W-1:0]  target,
	input  logic signed [plif_pkg::DATA_W-1:0]  measured,
	input  logic [plif_pkg::DT_W-1:0]           time_step,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [plif_pkg::DATA_W-1:0]  out_drive,
	output logic                                out_saturated,
	output logic                                out_zero_step
);
	import plif_pkg::*;

	function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
		return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
	endfunction

	// Item and loop state.
	logic signed [DATA_W-1:0] target_q;
	logic signed [DATA_W-1:0] err_q;
	logic signed [DATA_W-1:0] last_err_q;
	logic [DT_W-1:0]          dt_q;
	logic                     zstep_q;
	logic                     sat_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] deriv_q;
	logic signed [DATA_W-1:0] integ_q;
	logic signed [DATA_W-1:0] bracket_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     div_sel_q;
	logic                     div_neg_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     out_sat_q;
	logic                     out_zstep_q;

	// Combinational terms.
	plif_sat_t                err_sat;
	logic signed [OPND_W-1:0] mul_a;
	logic signed [OPND_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_shr_f;
	logic signed [PROD_W-1:0] prod_shr_d;
	logic signed [SUM_W-1:0]  prod_f;
	logic signed [SUM_W-1:0]  prod_d;
	logic signed [SUM_W-1:0]  acc_sum;
	logic signed [SUM_W-1:0]  drv_sum;
	plif_sat_t                acc_sat;
	plif_sat_t                br_sat;
	plif_sat_t                drv_sat;
	logic                     op_flag;

	logic signed [OPND_W-1:0] d_diff;
	logic [OPND_W-1:0]        d_abs;
	logic signed [ACC_W:0]    a_ext;
	logic [ACC_W:0]           a_abs;
	logic [DECAY_W:0]         leak;
	logic [DIV_N_W-1:0]       div_numer;
	logic [DIV_D_W-1:0]       div_denom;
	logic                     div_neg;

	logic                     div_busy;
	logic                     div_done;
	logic                     div_ovf;
	logic [DIV_Q_W-1:0]       div_quot;
	logic signed [SUM_W-1:0]  q_ext;
	logic signed [SUM_W-1:0]  q_signed;
	plif_sat_t                q_sat;

	assign err_sat = sat_to(ext_prod(PROD_W'($signed({target[DATA_W-1], target})
		- $signed({measured[DATA_W-1], measured}))), DATA_W);

	// Divider operands: the error difference over the time step, or the accumulator
	// scaled by one over the leak.
	always_comb begin
		d_diff    = $signed({err_q[DATA_W-1], err_q}) - $signed({last_err_q[DATA_W-1], last_err_q});
		d_abs     = d_diff[OPND_W-1] ? OPND_W'(-d_diff) : OPND_W'(d_diff);
		a_ext     = {acc_q[ACC_W-1], acc_q};
		a_abs     = a_ext[ACC_W] ? (ACC_W + 1)'(-a_ext) : (ACC_W + 1)'(a_ext);
		leak      = DECAY_ONE - {1'b0, cfg.decay};
		if (cmd.div_sel == DS_INTEG) begin
			div_numer = DIV_N_W'(a_abs[ACC_W-1:0]) << DECAY_W;
			div_denom = DIV_D_W'(leak);
			div_neg   = a_ext[ACC_W];
		end else begin
			div_numer = DIV_N_W'(d_abs[DATA_W-1:0]) << FRAC_BITS;
			div_denom = dt_q;
			div_neg   = d_diff[OPND_W-1];
		end
	end

	plif_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.busy   (div_busy),
		.done   (div_done),
		.ovf    (div_ovf),
		.quot   (div_quot)
	);

	// An overflowing quotient is replaced by a value that clamps either way.
	always_comb begin
		q_ext    = div_ovf ? (SUM_W'(1) << DIV_Q_W) : SUM_W'(div_quot);
		q_signed = div_neg_q ? -q_ext : q_ext;
		q_sat    = sat_to(q_signed, DATA_W);
	end

	always_comb begin
		case (cmd.mul_sel)
			MS_ACC_HI: begin
				mul_a = {acc_q[ACC_W-1], acc_q[ACC_W-1:DECAY_W]};
				mul_b = OPND_W'(cfg.decay);
			end
			MS_ACC_LO: begin
				mul_a = OPND_W'(acc_q[DECAY_W-1:0]);
				mul_b = OPND_W'(cfg.decay);
			end
			MS_ERR_DT: begin
				mul_a = {err_q[DATA_W-1], err_q};
				mul_b = OPND_W'(dt_q);
			end
			MS_KI: begin
				mul_a = {cfg.ki[DATA_W-1], cfg.ki};
				mul_b = {integ_q[DATA_W-1], integ_q};
			end
			MS_KD: begin
				mul_a = {cfg.kd[DATA_W-1], cfg.kd};
				mul_b = {deriv_q[DATA_W-1], deriv_q};
			end
			MS_KP: begin
				mul_a = {cfg.kp[DATA_W-1], cfg.kp};
				mul_b = {bracket_q[DATA_W-1], bracket_q};
			end
			MS_FF: begin
				mul_a = {target_q[DATA_W-1], target_q};
				mul_b = {cfg.kff[DATA_W-1], cfg.kff};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		prod_shr_f = prod_q >>> FRAC_BITS;
		prod_shr_d = prod_q >>> DECAY_W;
		prod_f     = ext_prod(prod_shr_f);
		prod_d     = ext_prod(prod_shr_d);
		acc_sum    = sum_q + prod_f;
		drv_sum    = cfg.ff_en ? (sum_q + prod_f) : sum_q;
		acc_sat    = sat_to(acc_sum, ACC_W);
		br_sat     = sat_to(acc_sum, DATA_W);
		drv_sat    = sat_to(drv_sum, DATA_W);
		case (cmd.op)
			OP_ACC:     op_flag = acc_sat.flag;
			OP_BRACKET: op_flag = br_sat.flag;
			OP_DRIVE:   op_flag = drv_sat.flag;
			default:    op_flag = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_sel != MS_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.op)
			OP_SUM_LOAD:   sum_q <= ext_prod(prod_q);
			OP_SUM_ADD_LO: sum_q <= sum_q + prod_d;
			OP_BR_INIT:    sum_q <= ext_prod(PROD_W'(err_q)) + prod_f;
			OP_DRV_INIT:   sum_q <= prod_f;
			default: ;
		endcase
		if (cmd.op == OP_BRACKET) begin
			bracket_q <= br_sat.val[DATA_W-1:0];
		end
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
			div_neg_q <= div_neg;
		end
		if (cmd.load) begin
			target_q <= target;
			err_q    <= err_sat.val[DATA_W-1:0];
			dt_q     <= time_step;
			zstep_q  <= (time_step == '0);
			sat_q    <= err_sat.flag;
			deriv_q  <= '0;
		end else begin
			sat_q <= sat_q | op_flag | (div_done & q_sat.flag);
			if (div_done) begin
				if (div_sel_q == DS_INTEG) begin
					integ_q <= q_sat.val[DATA_W-1:0];
				end else begin
					deriv_q <= q_sat.val[DATA_W-1:0];
				end
			end
		end
		if (cmd.op == OP_DRIVE) begin
			drive_q     <= cfg.ctl_en ? drv_sat.val[DATA_W-1:0] : target_q;
			out_sat_q   <= sat_q | drv_sat.flag;
			out_zstep_q <= zstep_q;
		end
	end

	// Loop state: cleared by reset and by any register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			last_err_q <= '0;
		end else if (clr) begin
			acc_q      <= '0;
			last_err_q <= '0;
		end else begin
			if (cmd.op == OP_ACC) begin
				acc_q <= acc_sat.val[ACC_W-1:0];
			end
			if (cmd.op == OP_DRIVE) begin
				last_err_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_DRIVE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_drive     = drive_q;
	assign out_saturated = out_sat_q;
	assign out_zero_step = out_zstep_q;

	assign stat.zero_step = zstep_q;
	assign stat.div_busy  = div_busy;
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

FILE: rtl/core/plif_ctrl.sv
// ----------------------------------------------------------------------------
// plif_ctrl
// Sequencer that walks one sample through the divider and the shared
// multiplier and hands the result to the output register.
// ----------------------------------------------------------------------------
module plif_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  plif_pkg::plif_stat_t stat,
	output plif_pkg::plif_cmd_t  cmd
);
	import plif_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DIV_D   = 4'd1;
	localparam logic [3:0] ST_WAIT_D  = 4'd2;
	localparam logic [3:0] ST_MUL_AH  = 4'd3;
	localparam logic [3:0] ST_MUL_AL  = 4'd4;
	localparam logic [3:0] ST_MUL_ED  = 4'd5;
	localparam logic [3:0] ST_ACC     = 4'd6;
	localparam logic [3:0] ST_DIV_I   = 4'd7;
	localparam logic [3:0] ST_WAIT_I  = 4'd8;
	localparam logic [3:0] ST_MUL_KI  = 4'd9;
	localparam logic [3:0] ST_MUL_KD  = 4'd10;
	localparam logic [3:0] ST_BRACKET = 4'd11;
	localparam logic [3:0] ST_MUL_KP  = 4'd12;
	localparam logic [3:0] ST_MUL_FF  = 4'd13;
	localparam logic [3:0] ST_DRIVE   = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DS_DERIV;
		cmd.mul_sel   = MS_NONE;
		cmd.op        = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV_D;
				end
			end
			ST_DIV_D: begin
				// With a zero time step the derivative stays at zero.
				if (stat.zero_step) begin
					state_d = ST_MUL_AH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_WAIT_D;
				end
			end
			ST_WAIT_D: begin
				if (stat.div_done) begin
					state_d = ST_MUL_AH;
				end
			end
			ST_MUL_AH: begin
				cmd.mul_sel = MS_ACC_HI;
				state_d     = ST_MUL_AL;
			end
			ST_MUL_AL: begin
				cmd.mul_sel = MS_ACC_LO;
				cmd.op      = OP_SUM_LOAD;
				state_d     = ST_MUL_ED;
			end
			ST_MUL_ED: begin
				cmd.mul_sel = MS_ERR_DT;
				cmd.op      = OP_SUM_ADD_LO;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_DIV_I;
			end
			ST_DIV_I: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_INTEG;
				state_d       = ST_WAIT_I;
			end
			ST_WAIT_I: begin
				if (stat.div_done) begin
					state_d = ST_MUL_KI;
				end
			end
			ST_MUL_KI: begin
				cmd.mul_sel = MS_KI;
				state_d     = ST_MUL_KD;
			end
			ST_MUL_KD: begin
				cmd.mul_sel = MS_KD;
				cmd.op      = OP_BR_INIT;
				state_d     = ST_BRACKET;
			end
			ST_BRACKET: begin
				cmd.op  = OP_BRACKET;
				state_d = ST_MUL_KP;
			end
			ST_MUL_KP: begin
				cmd.mul_sel = MS_KP;
				state_d     = ST_MUL_FF;
			end
			ST_MUL_FF: begin
				cmd.mul_sel = MS_FF;
				cmd.op      = OP_DRV_INIT;
				state_d     = ST_DRIVE;
			end
			ST_DRIVE: begin
				if (stat.out_free) begin
					cmd.op  = OP_DRIVE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/pid_leaky_integral_feedforward.sv
// ----------------------------------------------------------------------------
// pid_leaky_integral_feedforward
// PID controller with a leaky, normalized integral and setpoint feedforward.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. The input opens again once the result
// register of the sample has been loaded. Each sample passes through the
// radix-4 divider twice (derivative and normalized integral; once when
// time_step is zero) and through the single shared multiplier for seven
// products. The result register lets a finished result wait while the next
// sample is taken in.
// Writing any register clears the stored error and the integral accumulator;
// registers are meant to be written only while no sample is in flight.
module pid_leaky_integral_feedforward #(
	parameter int FRAC_BITS = plif_pkg::PLIF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [plif_pkg::ADDR_W-1:0] paddr,
	input  logic [plif_pkg::APB_W-1:0]  pwdata,
	output logic [plif_pkg::APB_W-1:0]  prdata,
	output logic                        pready,
	plif_sample_if.sink                 sample,
	plif_result_if.source               result
);
	import plif_pkg::*;

	plif_cfg_t  cfg;
	logic       clr;
	plif_cmd_t  cmd;
	plif_stat_t stat;

	plif_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.clr     (clr)
	);

	plif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	plif_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg           (cfg),
		.clr           (clr),
		.target        (sample.target),
		.measured      (sample.measured),
		.time_step     (sample.time_step),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_drive     (result.drive),
		.out_saturated (result.saturated),
		.out_zero_step (result.zero_step)
	);

	// A transfer in starts the sequence, so the input closes right after it.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("input still open after a transfer");

	a_div_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !sample.ready)
		else $error("divider busy while the input is open");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> stat.div_busy)
		else $error("divider did not start");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DRIVE |-> stat.out_free)
		else $error("result written over one still waiting");

endmodule
